// ===== rtl/core/apt_pkg.sv =====
`default_nettype none
package apt_pkg;

	// Fixed point format and datapath widths.
	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int OP_W = DATA_W + 1;
	localparam int PROD_W = DATA_W + OP_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int DIFF_W = PROD_W + 1;
	localparam int MAG_W = PROD_W;
	localparam int DPROD_W = 2 * DATA_W;
	localparam int DET_W = DPROD_W + 1;
	localparam int DMAG_W = DPROD_W;
	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int QUOT_W = DATA_W + 1;
	localparam int HI_W = NUM_W - QUOT_W;
	localparam int REM_W = DMAG_W + 1;
	localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;

	// Queue sizes.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// Command codes.
	localparam logic [1:0] CMD_FWD = 2'd0;
	localparam logic [1:0] CMD_VEC = 2'd1;
	localparam logic [1:0] CMD_INV = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
		logic signed [DATA_W-1:0] d;
		logic signed [DATA_W-1:0] tx;
		logic signed [DATA_W-1:0] ty;
	} coef_t;

	typedef struct packed {
		logic inv;
		logic tr;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rx;
		logic signed [DATA_W-1:0] ry;
		logic sing;
		logic sat;
	} result_t;

	typedef struct packed {
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic neg_x;
		logic neg_y;
		logic [DMAG_W-1:0] dmag;
	} div_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/apt_div.sv =====
`default_nettype none
module apt_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire apt_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output apt_pkg::result_t res,
	input wire logic ack
);
	import apt_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_x_q, rem_y_q;
	logic [QUOT_W-1:0] low_x_q, low_y_q;
	logic [QUOT_W-1:0] quot_x_q, quot_y_q;
	logic [DMAG_W-1:0] dmag_q;
	logic neg_x_q, neg_y_q, pre_x_q, pre_y_q;
	logic [REM_W:0] step_x, step_y;
	logic [DATA_W:0] fin_x, fin_y;

	// One restoring step: shift in a numerator bit, subtract if it fits.
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic nbit, input logic [DMAG_W-1:0] dmag);
		logic [REM_W-1:0] r2;
		r2 = {rem[REM_W-2:0], nbit};
		if (r2 >= REM_W'(dmag)) begin
			return {r2 - REM_W'(dmag), 1'b1};
		end
		return {r2, 1'b0};
	endfunction

	// Round to nearest with ties away from zero, apply sign and clip.
	function automatic logic [DATA_W:0] div_final(input logic [REM_W-1:0] rem,
			input logic [QUOT_W-1:0] quot, input logic [DMAG_W-1:0] dmag,
			input logic neg, input logic pre);
		logic rnd;
		logic [QUOT_W:0] qr, lim;
		logic [DATA_W-1:0] mag;
		rnd = {rem, 1'b0} >= (REM_W + 1)'(dmag);
		qr = (QUOT_W + 1)'(quot) + (QUOT_W + 1)'(rnd);
		lim = neg ? {{(QUOT_W + 1 - DATA_W){1'b0}}, SAT_MIN} :
			{{(QUOT_W + 1 - DATA_W){1'b0}}, SAT_MAX};
		mag = qr[DATA_W-1:0];
		if (pre || qr > lim) begin
			return {1'b1, neg ? SAT_MIN : SAT_MAX};
		end
		return {1'b0, neg ? (~mag + DATA_W'(1)) : mag};
	endfunction

	assign step_x = div_step(rem_x_q, low_x_q[QUOT_W-1], dmag_q);
	assign step_y = div_step(rem_y_q, low_y_q[QUOT_W-1], dmag_q);
	assign fin_x = div_final(rem_x_q, quot_x_q, dmag_q, neg_x_q, pre_x_q);
	assign fin_y = div_final(rem_y_q, quot_y_q, dmag_q, neg_y_q, pre_y_q);

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;
	assign res.rx = fin_x[DATA_W-1:0];
	assign res.ry = fin_y[DATA_W-1:0];
	assign res.sing = 1'b0;
	assign res.sat = fin_x[DATA_W] | fin_y[DATA_W];

	// Sequencer: load, one quotient bit per cycle, then hold the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of both axes; they share the divisor.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dmag_q <= req.dmag;
			neg_x_q <= req.neg_x;
			neg_y_q <= req.neg_y;
			pre_x_q <= CMP_W'(req.num_x[NUM_W-1:QUOT_W]) >= CMP_W'(req.dmag);
			pre_y_q <= CMP_W'(req.num_y[NUM_W-1:QUOT_W]) >= CMP_W'(req.dmag);
			rem_x_q <= REM_W'(req.num_x[NUM_W-1:QUOT_W]);
			rem_y_q <= REM_W'(req.num_y[NUM_W-1:QUOT_W]);
			low_x_q <= req.num_x[QUOT_W-1:0];
			low_y_q <= req.num_y[QUOT_W-1:0];
			quot_x_q <= '0;
			quot_y_q <= '0;
		end else if (state_q == ST_RUN) begin
			rem_x_q <= step_x[REM_W:1];
			rem_y_q <= step_y[REM_W:1];
			low_x_q <= {low_x_q[QUOT_W-2:0], 1'b0};
			low_y_q <= {low_y_q[QUOT_W-2:0], 1'b0};
			quot_x_q <= {quot_x_q[QUOT_W-2:0], step_x[0]};
			quot_y_q <= {quot_y_q[QUOT_W-2:0], step_y[0]};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/apt_front.sv =====
`default_nettype none
module apt_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [1:0] command,
	input wire logic signed [apt_pkg::DATA_W-1:0] point_x,
	input wire logic signed [apt_pkg::DATA_W-1:0] point_y,
	output logic head_valid,
	output apt_pkg::item_t head,
	input wire logic pop
);
	import apt_pkg::*;

	item_t mem_q [Q_DEPTH];
	item_t item;
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic do_push, do_pop;

	// Classify the command; an unused code runs as a forward request.
	always_comb begin
		item.inv = command == CMD_INV;
		item.tr = command != CMD_VEC;
		item.x = point_x;
		item.y = point_y;
	end

	assign full = count_q == Q_CNT_W'(Q_DEPTH);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/apt_back.sv =====
`default_nettype none
module apt_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire apt_pkg::coef_t coef,
	input wire logic head_valid,
	input wire apt_pkg::item_t head,
	output logic head_pop,
	output logic empty,
	input wire logic pop,
	output apt_pkg::result_t res
);
	import apt_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

	// Stage 1: operands.
	logic valid_s1, inv_s1, tr_s1;
	logic signed [OP_W-1:0] opx_s1, opy_s1;
	// Stage 2: products.
	logic valid_s2, inv_s2, tr_s2;
	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [DPROD_W-1:0] pad_s2, pbc_s2;
	// Stage 3: finished direct result (forward, vector or singular inverse) or divider request.
	logic valid_s3, div_s3;
	result_t res_s3;
	div_req_t req_s3;

	logic adv, s3_go, div_busy, div_done, div_ack;
	result_t div_res;
	logic signed [OP_W-1:0] opx, opy;
	logic signed [DATA_W-1:0] m0, m2a, m3a;
	logic signed [OP_W-1:0] o2, o3;
	logic signed [PROD_W-1:0] prod0, prod1, prod2, prod3;
	logic signed [DPROD_W-1:0] pad, pbc;
	logic [DATA_W:0] fx, fy;
	logic signed [DIFF_W-1:0] dx, dy, adx, ady;
	logic signed [DET_W-1:0] det, adet;
	result_t res_n;
	div_req_t req_n;
	logic sing_n;

	result_t ofifo_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] owr_q, ord_q;
	logic [Q_CNT_W-1:0] ocnt_q;
	logic ofull, owr, ord;
	result_t owdata;

	// Sum and round the two products, add the translation and clip to 32 bits.
	function automatic logic [DATA_W:0] fwd_axis(input logic signed [PROD_W-1:0] p,
			input logic signed [PROD_W-1:0] q, input logic signed [DATA_W-1:0] t);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(q) + HALF;
		s = (s >>> FRAC_BITS) + SUM_W'(t);
		if (s > SUM_W'(SAT_MAX)) begin
			return {1'b1, SAT_MAX};
		end
		if (s < SUM_W'(SAT_MIN)) begin
			return {1'b1, SAT_MIN};
		end
		return {1'b0, s[DATA_W-1:0]};
	endfunction

	// The pipeline moves as a whole; it waits on the divider and the result queue.
	assign ofull = ocnt_q == Q_CNT_W'(Q_DEPTH);
	assign s3_go = !div_busy && (div_s3 || !ofull);
	assign adv = !valid_s3 || s3_go;
	assign head_pop = adv && head_valid;
	assign div_ack = div_done && !ofull;

	// Inverse requests remove the translation before multiplying.
	always_comb begin
		opx = OP_W'(head.x);
		opy = OP_W'(head.y);
		if (head.inv) begin
			opx = OP_W'(head.x) - OP_W'(coef.tx);
			opy = OP_W'(head.y) - OP_W'(coef.ty);
		end
	end

	// Coefficient steering: forward uses a,c / b,d, inverse uses d,c / a,b.
	always_comb begin
		m0 = inv_s1 ? coef.d : coef.a;
		m2a = inv_s1 ? coef.a : coef.b;
		o2 = inv_s1 ? opy_s1 : opx_s1;
		m3a = inv_s1 ? coef.b : coef.d;
		o3 = inv_s1 ? opx_s1 : opy_s1;
		prod0 = PROD_W'(m0) * PROD_W'(opx_s1);
		prod1 = PROD_W'(coef.c) * PROD_W'(opy_s1);
		prod2 = PROD_W'(m2a) * PROD_W'(o2);
		prod3 = PROD_W'(m3a) * PROD_W'(o3);
		pad = DPROD_W'(coef.a) * DPROD_W'(coef.d);
		pbc = DPROD_W'(coef.b) * DPROD_W'(coef.c);
	end

	// Forward rounding, and numerators and determinant for the divider.
	always_comb begin
		fx = fwd_axis(p0_s2, p1_s2, tr_s2 ? coef.tx : '0);
		fy = fwd_axis(p2_s2, p3_s2, tr_s2 ? coef.ty : '0);
		dx = DIFF_W'(p0_s2) - DIFF_W'(p1_s2);
		dy = DIFF_W'(p2_s2) - DIFF_W'(p3_s2);
		det = DET_W'(pad_s2) - DET_W'(pbc_s2);
		adx = dx[DIFF_W-1] ? -dx : dx;
		ady = dy[DIFF_W-1] ? -dy : dy;
		adet = det[DET_W-1] ? -det : det;
		sing_n = det == '0;
		req_n.num_x = {adx[MAG_W-1:0], {FRAC_BITS{1'b0}}};
		req_n.num_y = {ady[MAG_W-1:0], {FRAC_BITS{1'b0}}};
		req_n.neg_x = dx[DIFF_W-1] ^ det[DET_W-1];
		req_n.neg_y = dy[DIFF_W-1] ^ det[DET_W-1];
		req_n.dmag = adet[DMAG_W-1:0];
		if (inv_s2) begin
			res_n.rx = '0;
			res_n.ry = '0;
			res_n.sing = sing_n;
			res_n.sat = 1'b0;
		end else begin
			res_n.rx = fx[DATA_W-1:0];
			res_n.ry = fy[DATA_W-1:0];
			res_n.sing = 1'b0;
			res_n.sat = fx[DATA_W] | fy[DATA_W];
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s1 <= head.inv;
			tr_s1 <= head.tr;
			opx_s1 <= opx;
			opy_s1 <= opy;
			inv_s2 <= inv_s1;
			tr_s2 <= tr_s1;
			p0_s2 <= prod0;
			p1_s2 <= prod1;
			p2_s2 <= prod2;
			p3_s2 <= prod3;
			pad_s2 <= pad;
			pbc_s2 <= pbc;
			div_s3 <= inv_s2 && !sing_n;
			res_s3 <= res_n;
			req_s3 <= req_n;
		end
	end

	apt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(valid_s3 && div_s3 && !div_busy),
		.req(req_s3),
		.busy(div_busy),
		.done(div_done),
		.res(div_res),
		.ack(div_ack)
	);

	// Result queue: written by the divider or by a direct result of stage 3.
	assign owr = div_ack || (valid_s3 && !div_s3 && s3_go);
	assign owdata = div_done ? div_res : res_s3;
	assign ord = pop && !empty;
	assign empty = ocnt_q == '0;
	assign res = ofifo_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (owr) begin
				owr_q <= owr_q + Q_PTR_W'(1);
			end
			if (ord) begin
				ord_q <= ord_q + Q_PTR_W'(1);
			end
			if (owr && !ord) begin
				ocnt_q <= ocnt_q + Q_CNT_W'(1);
			end else if (ord && !owr) begin
				ocnt_q <= ocnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (owr) begin
			ofifo_q[owr_q] <= owdata;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/affine_point_transform_core.sv =====
`default_nettype none
// Transforms 2D points in signed Q16.16 by the matrix [a c tx; b d ty] held in six
// configuration registers (index 0..5: a, b, c, d, offset x, offset y; writes to
// other indexes are dropped). Command 0 applies the full affine map, command 1 the
// linear part only, command 2 the inverse map; command 3 acts as command 0. Results
// saturate to 32 bits and flag it; an inverse of a singular matrix returns zeros with
// the singular flag set. Forward, vector and singular requests stream at one per
// cycle through a three stage multiply pipeline unless the divider or a full result
// queue holds it. A nonsingular inverse request runs through a shared bit-serial
// divider that yields one quotient bit per cycle and holds the pipeline until its
// result is queued. Results leave in request order through a four entry result
// queue; an input queue of four entries takes requests while the back end is busy.
module affine_point_transform_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [1:0] command,
	input wire logic signed [apt_pkg::DATA_W-1:0] point_x,
	input wire logic signed [apt_pkg::DATA_W-1:0] point_y,
	output logic empty,
	input wire logic pop,
	output logic signed [apt_pkg::DATA_W-1:0] result_x,
	output logic signed [apt_pkg::DATA_W-1:0] result_y,
	output logic singular,
	output logic saturated,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [apt_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [apt_pkg::DATA_W-1:0] cfg_data
);
	import apt_pkg::*;

	coef_t coef_q;
	item_t head;
	logic head_valid, head_pop;
	result_t res;

	assign cfg_ready = 1'b1;

	// Matrix and translation registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a <= FIX_ONE;
			coef_q.b <= '0;
			coef_q.c <= '0;
			coef_q.d <= FIX_ONE;
			coef_q.tx <= '0;
			coef_q.ty <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COEF_A: coef_q.a <= cfg_data;
				REG_COEF_B: coef_q.b <= cfg_data;
				REG_COEF_C: coef_q.c <= cfg_data;
				REG_COEF_D: coef_q.d <= cfg_data;
				REG_OFFSET_X: coef_q.tx <= cfg_data;
				REG_OFFSET_Y: coef_q.ty <= cfg_data;
				default: ;
			endcase
		end
	end

	apt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.point_x(point_x),
		.point_y(point_y),
		.head_valid(head_valid),
		.head(head),
		.pop(head_pop)
	);

	apt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef_q),
		.head_valid(head_valid),
		.head(head),
		.head_pop(head_pop),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	assign result_x = res.rx;
	assign result_y = res.ry;
	assign singular = res.sing;
	assign saturated = res.sat;

endmodule
`default_nettype wire
